// ===== rtl/mks_pkg.sv =====
// Shared constants, register indexes and key map for the matrix keypad scanner.
package mks_pkg;

    localparam int ROW_COUNT_DEF    = 4;
    localparam int COLUMN_COUNT_DEF = 4;

    localparam int COL_W   = 4;
    localparam int ROW_W   = 4;
    localparam int CODE_W  = 7;
    localparam int POS_W   = 4;
    localparam int DWELL_W = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_MODE = 1'b1;

    localparam logic MODE_DEBOUNCED = 1'b0;
    localparam logic MODE_LEVEL     = 1'b1;

    // Keys past the 4x4 map give code 0.
    localparam logic [CODE_W-1:0] KEY_NONE = 7'h00;

    typedef logic [CODE_W-1:0] key_code_t;

    function automatic key_code_t key_ascii(input logic [2:0] row, input logic [1:0] col);
        key_code_t code;
        code = KEY_NONE;
        if (row < 3'd4) begin
            unique case ({row[1:0], col})
                4'd0:    code = 7'h31;  // '1'
                4'd1:    code = 7'h32;  // '2'
                4'd2:    code = 7'h33;  // '3'
                4'd3:    code = 7'h41;  // 'A'
                4'd4:    code = 7'h34;  // '4'
                4'd5:    code = 7'h35;  // '5'
                4'd6:    code = 7'h36;  // '6'
                4'd7:    code = 7'h42;  // 'B'
                4'd8:    code = 7'h37;  // '7'
                4'd9:    code = 7'h38;  // '8'
                4'd10:   code = 7'h39;  // '9'
                4'd11:   code = 7'h43;  // 'C'
                4'd12:   code = 7'h2A;  // '*'
                4'd13:   code = 7'h30;  // '0'
                4'd14:   code = 7'h23;  // '#'
                default: code = 7'h44;  // 'D'
            endcase
        end
        return code;
    endfunction

endpackage

// ===== rtl/matrix_keypad_scanner.sv =====
// Matrix keypad scanner: row strobing, two-sample debounce (debounced mode) and key report per scan tick.
//
// Each accepted item is one scan tick carrying the column levels for the row driven
// during that tick. The result for a tick (the row drive that applied, and any key
// reported) is loaded into the result register when the item is accepted.
// One item is taken every cycle; s_ready drops only while a result sits in the
// result register and m_ready is low. Rows are held for dwell_ticks ticks (0 acts
// as 1); columns are sampled on the first and last tick of the dwell. In debounced
// mode a key reports once per press, in level mode on every decision tick it is low.
// A report restarts the scan at row 0. Configuration writes are always accepted.
module matrix_keypad_scanner #(
    parameter int ROW_COUNT    = mks_pkg::ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = mks_pkg::COLUMN_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mks_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mks_pkg::DWELL_W-1:0]   cfg_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mks_pkg::COL_W-1:0]     s_column_levels,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mks_pkg::ROW_W-1:0]     m_row_drive,
    output logic                          m_key_valid,
    output logic [mks_pkg::CODE_W-1:0]    m_key_code,
    output logic [mks_pkg::POS_W-1:0]     m_key_position
);

    localparam int RIDX_W    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int MARKS     = ROW_COUNT * COLUMN_COUNT;
    localparam int MIDX_W    = (MARKS > 1) ? $clog2(MARKS) : 1;
    localparam int SCAN_COLS = (COLUMN_COUNT < 4) ? COLUMN_COUNT : 4;
    localparam logic [RIDX_W-1:0] LAST_ROW = RIDX_W'(ROW_COUNT - 1);

    logic [mks_pkg::DWELL_W-1:0] dwell_ticks_reg;
    logic                        report_mode_reg;

    logic [RIDX_W-1:0]           current_row_reg, current_row_next;
    logic [mks_pkg::DWELL_W-1:0] dwell_count_reg, dwell_count_next;
    logic [mks_pkg::COL_W-1:0]   first_sample_reg, first_sample_next;
    logic [MARKS-1:0]            marks_reg, marks_next;

    logic                        out_valid_reg;
    logic [mks_pkg::ROW_W-1:0]   out_drive_reg, out_drive_next;
    logic                        out_key_valid_reg, out_key_valid_next;
    logic [mks_pkg::CODE_W-1:0]  out_code_reg, out_code_next;
    logic [mks_pkg::POS_W-1:0]   out_pos_reg, out_pos_next;

    logic take;

    assign cfg_ready = 1'b1;
    assign s_ready   = !out_valid_reg || m_ready;
    assign take      = s_valid && s_ready;

    assign m_valid        = out_valid_reg;
    assign m_row_drive    = out_drive_reg;
    assign m_key_valid    = out_key_valid_reg;
    assign m_key_code     = out_code_reg;
    assign m_key_position = out_pos_reg;

    always_comb begin
        logic [2:0]                  row_ext;
        logic [mks_pkg::COL_W-1:0]   first_eff;
        logic [mks_pkg::DWELL_W:0]   count_inc;
        logic [mks_pkg::DWELL_W:0]   dwell_eff;
        logic                        last_tick;
        logic                        found;
        logic [1:0]                  hit_col;
        logic                        low_last;
        logic                        down;
        logic [MIDX_W-1:0]           idx;

        row_ext   = 3'(current_row_reg);
        first_eff = (dwell_count_reg == '0) ? s_column_levels : first_sample_reg;
        count_inc = {1'b0, dwell_count_reg} + 1'b1;
        dwell_eff = (dwell_ticks_reg == '0) ? (mks_pkg::DWELL_W+1)'(1)
                                            : {1'b0, dwell_ticks_reg};
        last_tick = count_inc >= dwell_eff;

        for (int i = 0; i < mks_pkg::ROW_W; i++) begin
            out_drive_next[i] = (row_ext != 3'(i));
        end

        found      = 1'b0;
        hit_col    = 2'd0;
        marks_next = marks_reg;

        for (int j = 0; j < SCAN_COLS; j++) begin
            low_last = !s_column_levels[j];
            down     = low_last && !first_eff[j];
            idx      = MIDX_W'(int'(current_row_reg) * COLUMN_COUNT + j);
            if (last_tick && !found) begin
                if (report_mode_reg == mks_pkg::MODE_LEVEL) begin
                    if (low_last) begin
                        found   = 1'b1;
                        hit_col = 2'(j);
                    end
                end else begin
                    // first new press wins; stale marks ahead of it are released
                    if (down && !marks_reg[idx]) begin
                        marks_next[idx] = 1'b1;
                        found           = 1'b1;
                        hit_col         = 2'(j);
                    end else if (!down && marks_reg[idx]) begin
                        marks_next[idx] = 1'b0;
                    end
                end
            end
        end

        first_sample_next  = first_eff;
        out_key_valid_next = found;
        out_code_next      = found ? mks_pkg::key_ascii(row_ext, hit_col) : mks_pkg::KEY_NONE;
        out_pos_next       = found ? {row_ext[1:0], hit_col} : '0;

        if (!last_tick) begin
            dwell_count_next = count_inc[mks_pkg::DWELL_W-1:0];
            current_row_next = current_row_reg;
        end else begin
            dwell_count_next = '0;
            if (found || current_row_reg == LAST_ROW) begin
                current_row_next = '0;
            end else begin
                current_row_next = current_row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dwell_ticks_reg  <= mks_pkg::DWELL_RESET;
            report_mode_reg  <= mks_pkg::MODE_DEBOUNCED;
            current_row_reg  <= '0;
            dwell_count_reg  <= '0;
            first_sample_reg <= '1;
            marks_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    mks_pkg::CFG_DWELL_TICKS: dwell_ticks_reg <= cfg_data;
                    mks_pkg::CFG_REPORT_MODE: report_mode_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (take) begin
                current_row_reg  <= current_row_next;
                dwell_count_reg  <= dwell_count_next;
                first_sample_reg <= first_sample_next;
                marks_reg        <= marks_next;
                out_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_drive_reg     <= out_drive_next;
            out_key_valid_reg <= out_key_valid_next;
            out_code_reg      <= out_code_next;
            out_pos_reg       <= out_pos_next;
        end
    end

endmodule
